### hw/rtl/rfp_pkg.sv
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types, constants and the CRC byte update for the RLE packet framer.
// ----------------------------------------------------------------------------
package rfp_pkg;

    localparam logic [7:0]  SYNC_A   = 8'hAA;
    localparam logic [7:0]  SYNC_B   = 8'h55;
    localparam logic [7:0]  PKT_TYPE = 8'h02;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_TOP  = 16'h8000;
    localparam logic [7:0]  RUN_CAP  = 8'd255;

    // Byte slots of one command, in the order they go out on the wire.
    localparam int NUM_SLOTS = 12;

    typedef enum logic [3:0] {
        SLOT_SYNC_A  = 4'd0,
        SLOT_SYNC_B  = 4'd1,
        SLOT_TYPE    = 4'd2,
        SLOT_LEN_LO  = 4'd3,
        SLOT_LEN_HI  = 4'd4,
        SLOT_PAL     = 4'd5,
        SLOT_A_CNT   = 4'd6,
        SLOT_A_VAL   = 4'd7,
        SLOT_B_CNT   = 4'd8,
        SLOT_B_VAL   = 4'd9,
        SLOT_CRC_LO  = 4'd10,
        SLOT_CRC_HI  = 4'd11
    } slot_t;

    // Work for the back end caused by one accepted pixel.
    typedef struct packed {
        logic        hdr;
        logic [15:0] len;
        logic [7:0]  pal;
        logic        pair_a;
        logic [7:0]  a_cnt;
        logic [7:0]  a_val;
        logic        pair_b;
        logic [7:0]  b_cnt;
        logic [7:0]  b_val;
        logic        crc;
    } cmd_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((x & CRC_TOP) != 16'h0000)
                x = {x[14:0], 1'b0} ^ CRC_POLY;
            else
                x = {x[14:0], 1'b0};
        end
        return x;
    endfunction

endpackage

### hw/rtl/rle_frame_packetizer_crc16_unit.sv
// ----------------------------------------------------------------------------
// rle_frame_packetizer_crc16_unit
// Run-length packet framer with CRC-16/CCITT-FALSE over a byte stream.
// ----------------------------------------------------------------------------
// The bytes caused by a pixel pass through the command queue and then the
// registered output word; m_tvalid rises together with the first of them.
// Throughput: a pixel is taken every cycle while the queue has room; bytes
// leave at one per cycle while the receiver is ready, so a send-pass stream
// in which every pixel ends a run is paced by the single byte emitter, as
// each such pixel causes two bytes.
// Reset: rst_n clears pass and run state, sets the CRC to its initial value,
// empties the queue and drops m_tvalid; palette_index returns to zero.
// ----------------------------------------------------------------------------
module rle_frame_packetizer_crc16_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,

    // Configuration: palette_index, written whenever cfg_wr_en is high.
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,

    // Pixel input.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] pixel
    input  logic       s_tuser,     // [0] func (0 measure pass, 1 send pass)
    input  logic       s_tlast,     // last_pixel

    // Packet byte output.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [7:0] out_byte
    output logic       m_tuser,     // [0] end_of_group
    output logic       m_tlast      // end_of_packet
);
    import rfp_pkg::*;

    // The front end follows runs across both passes. Each pixel that causes
    // bytes leaves one command in the queue: an optional header, up to two
    // count,value pairs (the run this pixel closes and, on the last pixel,
    // the run it ends in) and an optional CRC trailer.
    logic  push_valid, push_ready;
    cmd_t  push_data;
    logic  head_valid, head_pop;
    cmd_t  head_data;

    rfp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pix_valid   (s_tvalid),
        .pix_send    (s_tuser),
        .pix_value   (s_tdata),
        .pix_last    (s_tlast),
        .pix_ready   (s_tready),
        .cmd_valid   (push_valid),
        .cmd_data    (push_data),
        .cmd_ready   (push_ready)
    );

    // The queue lets the front keep taking pixels while the back end is
    // still sending a header or is held by the downstream side.
    rfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data (push_data),
        .not_full  (push_ready),
        .not_empty (head_valid),
        .head_data (head_data),
        .pop       (head_pop)
    );

    // The back end sends the bytes of each command in wire order and runs
    // the CRC over the type, length, palette and run bytes.
    rfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd_data  (head_data),
        .cmd_pop   (head_pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_byte    (m_tdata),
        .m_eog     (m_tuser),
        .m_eop     (m_tlast)
    );

endmodule

### hw/rtl/rfp_front.sv
// ----------------------------------------------------------------------------
// rfp_front
// Takes pixels, tracks runs and the run total, and turns each pixel that
// causes bytes into a command for the byte emitter.
// ----------------------------------------------------------------------------
module rfp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  logic               pix_valid,
    input  logic               pix_send,
    input  logic [7:0]         pix_value,
    input  logic               pix_last,
    output logic               pix_ready,
    output logic               cmd_valid,
    output rfp_pkg::cmd_t      cmd_data,
    input  logic               cmd_ready
);
    import rfp_pkg::*;

    logic        pass_open_reg, pass_open_next;
    logic [7:0]  run_value_reg, run_value_next;
    logic [7:0]  run_length_reg, run_length_next;
    logic [15:0] run_total_reg, run_total_next;
    logic [7:0]  palette_reg;
    logic        accept;
    cmd_t        cmd;

    // The queue must have room even for pixels that cause no bytes.
    assign pix_ready = cmd_ready;
    assign accept    = pix_valid && cmd_ready;

    always_comb
    begin
        cmd             = '0;
        pass_open_next  = pass_open_reg;
        run_value_next  = run_value_reg;
        run_length_next = run_length_reg;
        run_total_next  = run_total_reg;

        if (pass_open_reg)
        begin
            if (pix_value == run_value_reg && run_length_reg < RUN_CAP)
            begin
                run_length_next = run_length_reg + 8'd1;
            end
            else
            begin
                if (pix_send)
                begin
                    cmd.pair_a = 1'b1;
                    cmd.a_cnt  = run_length_reg;
                    cmd.a_val  = run_value_reg;
                end
                else
                begin
                    run_total_next = run_total_reg + 16'd1;
                end
                run_value_next  = pix_value;
                run_length_next = 8'd1;
            end
        end
        else
        begin
            pass_open_next = 1'b1;
            if (pix_send)
            begin
                cmd.hdr = 1'b1;
                cmd.len = {run_total_reg[14:0], 1'b1};
                cmd.pal = palette_reg;
            end
            else
            begin
                run_total_next = 16'd0;
            end
            run_value_next  = pix_value;
            run_length_next = 8'd1;
        end

        if (pix_last)
        begin
            if (pix_send)
            begin
                cmd.pair_b = 1'b1;
                cmd.b_cnt  = run_length_next;
                cmd.b_val  = run_value_next;
                cmd.crc    = 1'b1;
            end
            else
            begin
                run_total_next = run_total_next + 16'd1;
            end
            pass_open_next  = 1'b0;
            run_length_next = 8'd0;
        end
    end

    assign cmd_data  = cmd;
    assign cmd_valid = accept && (cmd.hdr || cmd.pair_a || cmd.pair_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_open_reg  <= 1'b0;
            run_value_reg  <= 8'd0;
            run_length_reg <= 8'd0;
            run_total_reg  <= 16'd0;
            palette_reg    <= 8'd0;
        end
        else
        begin
            if (accept)
            begin
                pass_open_reg  <= pass_open_next;
                run_value_reg  <= run_value_next;
                run_length_reg <= run_length_next;
                run_total_reg  <= run_total_next;
            end
            if (cfg_wr_en)
                palette_reg <= cfg_wr_data;
        end
    end

endmodule

### hw/rtl/rfp_queue.sv
// ----------------------------------------------------------------------------
// rfp_queue
// Small first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module rfp_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rfp_pkg::cmd_t  push_data,
    output logic           not_full,
    output logic           not_empty,
    output rfp_pkg::cmd_t  head_data,
    input  logic           pop
);
    import rfp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    cmd_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign not_full  = (count_reg != CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = entry_reg[rd_ptr_reg];
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### hw/rtl/rfp_back.sv
// ----------------------------------------------------------------------------
// rfp_back
// Walks the byte slots of each command, one byte a cycle unless the output
// stalls, keeps the running CRC and drives the registered output word.
// ----------------------------------------------------------------------------
module rfp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  rfp_pkg::cmd_t  cmd_data,
    output logic           cmd_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_byte,
    output logic           m_eog,
    output logic           m_eop
);
    import rfp_pkg::*;

    logic [NUM_SLOTS-1:0] remaining_reg, remaining_next;
    logic                 busy_reg, busy_next;
    logic [15:0]          crc_reg, crc_next;
    logic                 valid_reg;
    logic [7:0]           byte_reg;
    logic                 eog_reg, eop_reg;

    logic [NUM_SLOTS-1:0] head_mask, rem, low_bit, rem_after;
    slot_t                slot;
    logic [7:0]           cur_byte;
    logic                 emit;

    // Slots present in the command at the head of the queue.
    always_comb
    begin
        head_mask = '0;
        head_mask[SLOT_SYNC_A] = cmd_data.hdr;
        head_mask[SLOT_SYNC_B] = cmd_data.hdr;
        head_mask[SLOT_TYPE]   = cmd_data.hdr;
        head_mask[SLOT_LEN_LO] = cmd_data.hdr;
        head_mask[SLOT_LEN_HI] = cmd_data.hdr;
        head_mask[SLOT_PAL]    = cmd_data.hdr;
        head_mask[SLOT_A_CNT]  = cmd_data.pair_a;
        head_mask[SLOT_A_VAL]  = cmd_data.pair_a;
        head_mask[SLOT_B_CNT]  = cmd_data.pair_b;
        head_mask[SLOT_B_VAL]  = cmd_data.pair_b;
        head_mask[SLOT_CRC_LO] = cmd_data.crc;
        head_mask[SLOT_CRC_HI] = cmd_data.crc;
    end

    assign rem       = busy_reg ? remaining_reg : head_mask;
    assign low_bit   = rem & (~rem + 1'b1);
    assign rem_after = rem & ~low_bit;
    assign emit      = cmd_valid && (!valid_reg || m_ready);
    assign cmd_pop   = emit && (rem_after == '0);

    always_comb
    begin
        slot = SLOT_SYNC_A;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (rem[i])
                slot = slot_t'(i[3:0]);
        end
    end

    always_comb
    begin
        case (slot)
            SLOT_SYNC_A: cur_byte = SYNC_A;
            SLOT_SYNC_B: cur_byte = SYNC_B;
            SLOT_TYPE:   cur_byte = PKT_TYPE;
            SLOT_LEN_LO: cur_byte = cmd_data.len[7:0];
            SLOT_LEN_HI: cur_byte = cmd_data.len[15:8];
            SLOT_PAL:    cur_byte = cmd_data.pal;
            SLOT_A_CNT:  cur_byte = cmd_data.a_cnt;
            SLOT_A_VAL:  cur_byte = cmd_data.a_val;
            SLOT_B_CNT:  cur_byte = cmd_data.b_cnt;
            SLOT_B_VAL:  cur_byte = cmd_data.b_val;
            SLOT_CRC_LO: cur_byte = crc_reg[7:0];
            SLOT_CRC_HI: cur_byte = crc_reg[15:8];
            default:     cur_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        remaining_next = remaining_reg;
        busy_next      = busy_reg;
        crc_next       = crc_reg;
        if (emit)
        begin
            remaining_next = rem_after;
            busy_next      = (rem_after != '0);
            // The packet type opens the CRC; the sync and CRC bytes leave it alone.
            if (slot == SLOT_TYPE)
                crc_next = crc_byte(CRC_INIT, cur_byte);
            else if (slot != SLOT_SYNC_A && slot != SLOT_SYNC_B &&
                     slot != SLOT_CRC_LO && slot != SLOT_CRC_HI)
                crc_next = crc_byte(crc_reg, cur_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            busy_reg      <= 1'b0;
            crc_reg       <= CRC_INIT;
            valid_reg     <= 1'b0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            busy_reg      <= busy_next;
            crc_reg       <= crc_next;
            if (emit)
                valid_reg <= 1'b1;
            else if (m_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg <= cur_byte;
            eog_reg  <= (rem_after == '0);
            eop_reg  <= (slot == SLOT_CRC_HI);
        end
    end

    assign m_valid = valid_reg;
    assign m_byte  = byte_reg;
    assign m_eog   = eog_reg;
    assign m_eop   = eop_reg;

endmodule

### sim/rle_frame_packetizer_crc16_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle_frame_packetizer_crc16_unit_tb
// Self-checking bench for the run-length packet framer. A table of directed
// frames is played first, then randomly built frames, each normally shown
// once as a measure pass and once as a send pass. Every accepted pixel word
// is run through a behavioural model of the framer. The bytes that the model
// expects wait in a queue, and each byte word that leaves the block is
// compared against the oldest of them.
// ----------------------------------------------------------------------------
module rle_frame_packetizer_crc16_unit_tb;

    import rfp_pkg::*;

    localparam logic FUNC_MEASURE  = 1'b0;
    localparam logic FUNC_SEND     = 1'b1;

    // A pixel's bytes leave through the command queue and the output register,
    // never at the edge that accepts the pixel. Measure pixels cause no bytes,
    // so a spare margin is allowed before the block is taken to be idle.
    localparam int   SETTLE_CYCLES = 8;
    localparam int   HOLD_CYCLES   = 300;
    localparam int   RANDOM_PIXELS = 40;
    localparam int   IDLE_PERCENT  = 29;
    localparam int   MAX_FRAME     = 48;
    localparam int   HOLD_FRAME    = 0;
    localparam int   HOLD_PIXELS   = 16;
    localparam int   CALM_REPS     = 100;
    localparam int   NUM_ROWS      = 19;

    typedef enum logic {
        ROW_PIXEL,
        ROW_PALETTE
    } row_kind_t;

    // One line of the directed table. A pixel row is repeated reps times,
    // and only its final repetition carries last. For a palette row, value
    // is the register contents. Where len_chk is set, the header length
    // bytes are taken from len_val instead of the model.
    typedef struct {
        row_kind_t   kind;
        logic        func;
        logic [7:0]  value;
        logic        last;
        int          reps;
        logic        len_chk;
        logic [15:0] len_val;
    } dir_row_t;

    typedef struct {
        logic [7:0] data;
        logic       eog;
        logic       eop;
    } pkt_byte_t;

    dir_row_t dir_tab [NUM_ROWS] = '{
        // Send pass straight after reset: no runs counted, length 1.
        '{ROW_PIXEL,   FUNC_SEND,    8'h00, 1'b1,   1, 1'b1, 16'h0001},
        '{ROW_PALETTE, FUNC_MEASURE, 8'hFF, 1'b0,   1, 1'b0, 16'h0000},
        // Two runs measured, then sent: length 5.
        '{ROW_PIXEL,   FUNC_MEASURE, 8'hFF, 1'b0,   2, 1'b0, 16'h0000},
        '{ROW_PIXEL,   FUNC_MEASURE, 8'h00, 1'b1,   1, 1'b0, 16'h0000},
        '{ROW_PIXEL,   FUNC_SEND,    8'hFF, 1'b0,   2, 1'b1, 16'h0005},
        '{ROW_PIXEL,   FUNC_SEND,    8'h00, 1'b1,   1, 1'b0, 16'h0000},
        // The run count survives a send pass. This one-pixel pass also
        // gives the longest burst of bytes from a single word.
        '{ROW_PIXEL,   FUNC_SEND,    8'hA5, 1'b1,   1, 1'b1, 16'h0005},
        // The pass kind changes word by word. Three runs are counted.
        '{ROW_PIXEL,   FUNC_MEASURE, 8'h12, 1'b0,   1, 1'b0, 16'h0000},
        '{ROW_PIXEL,   FUNC_SEND,    8'h34, 1'b0,   1, 1'b0, 16'h0000},
        '{ROW_PIXEL,   FUNC_MEASURE, 8'h56, 1'b0,   1, 1'b0, 16'h0000},
        '{ROW_PIXEL,   FUNC_SEND,    8'h56, 1'b0,   1, 1'b0, 16'h0000},
        '{ROW_PIXEL,   FUNC_MEASURE, 8'h78, 1'b1,   1, 1'b0, 16'h0000},
        '{ROW_PIXEL,   FUNC_SEND,    8'h78, 1'b1,   1, 1'b1, 16'h0007},
        // A measure pass that ends on a send pixel emits run pairs and a
        // CRC but no header.
        '{ROW_PIXEL,   FUNC_MEASURE, 8'h01, 1'b0,   1, 1'b0, 16'h0000},
        '{ROW_PIXEL,   FUNC_SEND,    8'h02, 1'b1,   1, 1'b0, 16'h0000},
        '{ROW_PALETTE, FUNC_MEASURE, 8'h00, 1'b0,   1, 1'b0, 16'h0000},
        // One pixel past the run cap splits the run in two. No runs were
        // counted by the pass before, so the length is 1.
        '{ROW_PIXEL,   FUNC_SEND,    8'h80, 1'b1, 256, 1'b1, 16'h0001},
        // A send pass that ends on a measure pixel: header, no CRC.
        '{ROW_PIXEL,   FUNC_SEND,    8'h11, 1'b0,   1, 1'b0, 16'h0000},
        '{ROW_PIXEL,   FUNC_MEASURE, 8'h22, 1'b1,   1, 1'b0, 16'h0000}
    };

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'h00;
    logic        s_tuser     = 1'b0;
    logic        s_tlast     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // Typed length check travelling alongside the pixel word.
    logic        len_chk_w   = 1'b0;
    logic [15:0] len_val_w   = 16'h0000;

    // Stimulus controls: calm switches idling off on both sides, and
    // hold_go starts the single long hold-off of the receiver.
    logic        calm        = 1'b0;
    logic        hold_go     = 1'b0;

    int          errors      = 0;
    int          pixels_sent = 0;
    int          mon_first;
    pkt_byte_t   want;
    pkt_byte_t   pkt_q [$];
    logic [7:0]  frame_px [MAX_FRAME];

    // Framer state as the model sees it.
    logic        fr_open     = 1'b0;
    logic [7:0]  fr_run_val  = 8'h00;
    logic [7:0]  fr_run_len  = 8'h00;
    logic [15:0] fr_runs     = 16'h0000;
    logic [15:0] fr_crc      = CRC_INIT;
    logic [7:0]  fr_palette  = 8'h00;

    rle_frame_packetizer_crc16_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // CRC-16/CCITT-FALSE, one bit at a time, MSB first.
    function automatic logic [15:0] crc_ccitt(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int k = 7; k >= 0; k--)
        begin
            fb = r[15] ^ b[k];
            r  = {r[14:0], 1'b0};
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    // Queues one expected byte; covered bytes also feed the running CRC.
    function automatic void emit_byte(input logic [7:0] b, input logic eop,
                                      input logic covered);
        pkt_byte_t e;
        e.data = b;
        e.eog  = 1'b0;
        e.eop  = eop;
        pkt_q.push_back(e);
        if (covered)
            fr_crc = crc_ccitt(fr_crc, b);
    endfunction

    // A closed run is either counted or sent, by the kind of the pixel
    // that closes it.
    function automatic void close_run(input logic send);
        if (send)
        begin
            emit_byte(fr_run_len, 1'b0, 1'b1);
            emit_byte(fr_run_val, 1'b0, 1'b1);
        end
        else
            fr_runs = fr_runs + 16'd1;
    endfunction

    // Works out the bytes that one accepted pixel causes and returns the
    // queue position of the first of them.
    function automatic int predict_pixel(input logic send, input logic [7:0] px,
                                         input logic last);
        int          first;
        logic [15:0] len;
        first = pkt_q.size();
        if (fr_open)
        begin
            if (px == fr_run_val && fr_run_len != RUN_CAP)
                fr_run_len = fr_run_len + 8'd1;
            else
            begin
                close_run(send);
                fr_run_val = px;
                fr_run_len = 8'd1;
            end
        end
        else
        begin
            fr_open = 1'b1;
            if (send)
            begin
                // Length wraps at 16 bits along with the run count.
                len    = {fr_runs[14:0], 1'b0} + 16'd1;
                fr_crc = CRC_INIT;
                emit_byte(SYNC_A, 1'b0, 1'b0);
                emit_byte(SYNC_B, 1'b0, 1'b0);
                emit_byte(PKT_TYPE, 1'b0, 1'b1);
                emit_byte(len[7:0], 1'b0, 1'b1);
                emit_byte(len[15:8], 1'b0, 1'b1);
                emit_byte(fr_palette, 1'b0, 1'b1);
            end
            else
                fr_runs = 16'h0000;
            fr_run_val = px;
            fr_run_len = 8'd1;
        end
        if (last)
        begin
            close_run(send);
            if (send)
            begin
                emit_byte(fr_crc[7:0], 1'b0, 1'b0);
                emit_byte(fr_crc[15:8], 1'b1, 1'b0);
            end
            fr_open    = 1'b0;
            fr_run_len = 8'd0;
        end
        if (pkt_q.size() > first)
            pkt_q[pkt_q.size() - 1].eog = 1'b1;
        return first;
    endfunction

    // Both handshakes are sampled at the same edge, as the block sees
    // them. A pixel's bytes cannot leave at the edge that accepts it, so
    // prediction may safely come first.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            mon_first = predict_pixel(s_tuser, s_tdata, s_tlast);
            if (len_chk_w && pkt_q.size() >= mon_first + 5)
            begin
                pkt_q[mon_first + 3].data = len_val_w[7:0];
                pkt_q[mon_first + 4].data = len_val_w[15:8];
            end
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pkt_q.size() == 0)
            begin
                $error("unexpected output word: out_byte %02h", m_tdata);
                errors++;
            end
            else
            begin
                want = pkt_q.pop_front();
                if (m_tdata !== want.data)
                begin
                    $error("out_byte: expected %02h, got %02h", want.data, m_tdata);
                    errors++;
                end
                if (m_tuser !== want.eog)
                begin
                    $error("end_of_group: expected %0b, got %0b", want.eog, m_tuser);
                    errors++;
                end
                if (m_tlast !== want.eop)
                begin
                    $error("end_of_packet: expected %0b, got %0b", want.eop, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Receiver. It idles at random outside calm stretches. Once hold_go
    // rises it refuses bytes while its held count is below the hold limit,
    // so that the command queue fills and the block stops taking pixels.
    initial
    begin : sink
        int held;
        held = 0;
        forever
        begin
            @(posedge clk);
            if (hold_go && held < HOLD_CYCLES)
            begin
                m_tready <= 1'b0;
                held++;
            end
            else if (calm)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Offers one pixel word and returns at the edge that accepts it. Each
    // cycle before it may be idle at random. When there is no idle cycle,
    // tvalid simply stays high for the next word.
    task automatic send_word(input logic func, input logic [7:0] px, input logic last,
                             input logic chk, input logic [15:0] len);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= func;
        s_tdata   <= px;
        s_tlast   <= last;
        len_chk_w <= chk;
        len_val_w <= len;
        do
            @(posedge clk);
        while (!s_tready);
        pixels_sent++;
    endtask

    // Stops offering pixels and waits for every expected byte, plus a
    // margin for measure pixels still in flight. The first edge lets the
    // model take in the pixel accepted just before.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pkt_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The palette is only rewritten while the block is idle.
    task automatic write_palette(input logic [7:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        fr_palette   = v;
    endtask

    // Presents the current frame buffer as one complete pass.
    task automatic run_pass(input logic func, input int n);
        for (int i = 0; i < n; i++)
            send_word(func, frame_px[i], i == n - 1, 1'b0, 16'h0000);
    endtask

    initial
    begin : stim
        int         r;
        int         i;
        int         n;
        int         mode;
        int         frame;
        logic       alpha;
        logic [7:0] a;
        logic [7:0] b;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. The long run past the cap is played with no
        // idling on either side.
        for (r = 0; r < NUM_ROWS; r++)
        begin
            if (dir_tab[r].kind == ROW_PALETTE)
                write_palette(dir_tab[r].value);
            else
            begin
                calm <= (dir_tab[r].reps >= CALM_REPS);
                for (i = 0; i < dir_tab[r].reps; i++)
                    send_word(dir_tab[r].func, dir_tab[r].value,
                              dir_tab[r].last && i == dir_tab[r].reps - 1,
                              dir_tab[r].len_chk && i == 0, dir_tab[r].len_val);
            end
        end
        settle();

        // Random frames. Most are a well-formed measure pass followed by a
        // send pass of the same pixels. The rest are noise, a lone measure
        // pass or a lone send pass.
        pixels_sent = 0;
        frame       = 0;
        while (pixels_sent < RANDOM_PIXELS)
        begin
            calm <= 1'b0;
            if ($urandom_range(0, 4) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       write_palette(8'h00);
                    1:       write_palette(8'hFF);
                    default: write_palette(8'($urandom));
                endcase
            end
            n     = (frame == HOLD_FRAME) ? HOLD_PIXELS : $urandom_range(1, 16);
            a     = 8'($urandom);
            b     = 8'($urandom);
            alpha = 1'($urandom_range(0, 1));
            for (i = 0; i < n; i++)
            begin
                if (frame == HOLD_FRAME)
                    frame_px[i] = 8'(a + 3 * i);   // every pixel ends a run
                else if (alpha)
                    frame_px[i] = ($urandom_range(0, 2) == 0) ? b : a;
                else
                    frame_px[i] = 8'($urandom);
            end
            mode = (frame == HOLD_FRAME) ? 0 : $urandom_range(0, 9);
            if (mode <= 6)
            begin
                run_pass(FUNC_MEASURE, n);
                // The long hold-off falls on a dense send pass, so that
                // bytes pile up while pixels keep being offered.
                if (frame == HOLD_FRAME)
                    hold_go <= 1'b1;
                run_pass(FUNC_SEND, n);
            end
            else if (mode == 7)
            begin
                for (i = 0; i < n; i++)
                    send_word(1'($urandom_range(0, 1)), frame_px[i],
                              i == n - 1 || $urandom_range(0, 5) == 0, 1'b0, 16'h0000);
            end
            else if (mode == 8)
                run_pass(FUNC_MEASURE, n);
            else
                run_pass(FUNC_SEND, n);
            frame++;
        end

        settle();
        if (errors == 0 && pkt_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### rle_frame_packetizer_crc16_unit.f
hw/rtl/rfp_pkg.sv
hw/rtl/rfp_front.sv
hw/rtl/rfp_queue.sv
hw/rtl/rfp_back.sv
hw/rtl/rle_frame_packetizer_crc16_unit.sv
sim/rle_frame_packetizer_crc16_unit_tb.sv
